FILE: sv/skvm_pkg.sv
// ----------------------------------------------------------------------------
// skvm_pkg: shared types and codes of the sorted key/value map
// Word layouts, command and status codes, and storage entry format.
// ----------------------------------------------------------------------------
package skvm_pkg;

  localparam int CMD_W        = 3;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int ST_W         = 4;
  localparam int CNT_W        = 7;
  localparam int CAPACITY_DEF = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 4'd0;
  localparam logic [ST_W-1:0] ST_UPDATED  = 4'd1;
  localparam logic [ST_W-1:0] ST_FOUND    = 4'd2;
  localparam logic [ST_W-1:0] ST_MISSING  = 4'd3;
  localparam logic [ST_W-1:0] ST_REMOVED  = 4'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 4'd5;
  localparam logic [ST_W-1:0] ST_CLEARED  = 4'd6;
  localparam logic [ST_W-1:0] ST_DUMP     = 4'd7;
  localparam logic [ST_W-1:0] ST_EMPTY    = 4'd8;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] out_key;
    logic [VAL_W-1:0] out_value;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

FILE: sv/skvm_mem.sv
// ----------------------------------------------------------------------------
// skvm_mem: entry storage
// One write port and one read port, read data registered, held when idle.
// ----------------------------------------------------------------------------
module skvm_mem #(
  parameter int DEPTH = skvm_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  skvm_pkg::entry_t         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output skvm_pkg::entry_t         rdata
);
  import skvm_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/skvm_outreg.sv
// ----------------------------------------------------------------------------
// skvm_outreg: result word register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module skvm_outreg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  skvm_pkg::rsp_t din,
  output logic           free,
  output logic           valid,
  input  logic           ready,
  output skvm_pkg::rsp_t dout
);
  import skvm_pkg::*;

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("result loaded over a word not yet taken");
  a_load_shows: assert property (@(posedge clk) disable iff (rst) load |=> valid)
    else $error("loaded result word not presented");
  a_drop_taken: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready && !load) |=> valid)
    else $error("result word dropped before being taken");
`endif

endmodule

FILE: sv/sorted_key_value_map.sv
// search: binary search, each probe a read (S_PROBE) and a compare (S_CMP), then a
//   hit check (S_HIT); insert shifts the entries from the slot up (none when appending
//   at the top), remove shifts the entries above it down (none for the top entry), then
//   the result word is loaded into the output register
// throughput: one command at a time, accepted only in idle; dump reads one entry at a
//   time through the single memory read port; slower if the consumer stalls
// reset: synchronous, clears count and control; storage contents are left as they are
// ----------------------------------------------------------------------------
// sorted_key_value_map: fixed-capacity map kept sorted by key
// Binary search over a one-port-read memory, shifted in place on insert and
// remove, with one registered result word toward the consumer.
// ----------------------------------------------------------------------------
module sorted_key_value_map #(
  parameter int CAPACITY = skvm_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  skvm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output skvm_pkg::rsp_t rsp
);
  import skvm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_HIT, S_SHIFT, S_PLACE, S_EMIT, S_DREAD, S_DEMIT
  } state_t;

  state_t           state;
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lo;        // search window, lower bound ends up here
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] rd_ptr;    // shift read pointer
  logic             rd_more;
  logic             pend;      // a shift read is in flight, write it back
  logic [CNT_W-1:0] pend_addr;
  logic             shift_up;
  logic [CNT_W-1:0] dump_ptr;
  logic [ST_W-1:0]  res_status;
  logic [VAL_W-1:0] res_value;

  logic [CNT_W-1:0] mid;
  logic             hit;
  logic             shift_last;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  entry_t           mem_rdata;

  logic             res_load;
  logic             out_free;
  rsp_t             res_word;

  assign req_ready = (state == S_IDLE);
  assign mid       = lo + ((hi - lo) >> 1);
  // lower bound hit: inside the table and the key matches
  assign hit       = (lo < count) && (mem_rdata.key == key_q);
  // final move of a shift: reached the slot at pos (insert), or the top entry (remove)
  assign shift_last = shift_up ? (rd_ptr == lo) : (rd_ptr == count - 1'b1);

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = lo[AW-1:0];
    mem_wdata = '{key: key_q, value: value_q};
    unique case (state)
      S_PROBE: begin
        // probe the midpoint, or fetch the lower bound once the window closes
        mem_re    = 1'b1;
        mem_raddr = (lo < hi) ? mid[AW-1:0] : lo[AW-1:0];
      end
      S_HIT: begin
        // existing key on insert: overwrite in place
        mem_we = (cmd_q == CMD_INSERT) && hit;
      end
      S_SHIFT: begin
        // read one slot while writing the previous read one step over
        mem_re    = rd_more;
        mem_raddr = rd_ptr[AW-1:0];
        mem_we    = pend;
        mem_waddr = pend_addr[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_PLACE: begin
        mem_we = 1'b1;
      end
      S_DREAD: begin
        mem_re    = 1'b1;
        mem_raddr = dump_ptr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // result word toward the output register
  always_comb begin
    res_load = 1'b0;
    res_word = '{status: res_status, out_key: key_q, out_value: res_value,
                 entry_count: count, last: 1'b1};
    if (state == S_EMIT) begin
      res_load = out_free;
    end else if (state == S_DEMIT) begin
      res_load = out_free;
      res_word = '{status: ST_DUMP, out_key: mem_rdata.key,
                   out_value: mem_rdata.value, entry_count: count,
                   last: (dump_ptr == count - 1'b1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q     <= req.cmd;
            key_q     <= req.key;
            value_q   <= req.value;
            lo        <= '0;
            hi        <= count;
            dump_ptr  <= '0;
            res_value <= '0;
            unique case (req.cmd)
              CMD_INSERT, CMD_FIND, CMD_REMOVE: begin
                state <= S_PROBE;
              end
              CMD_CLEAR: begin
                count      <= '0;
                res_status <= ST_CLEARED;
                state      <= S_EMIT;
              end
              CMD_DUMP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_DREAD;
                end
              end
              default: begin
                // unused codes: no change, no result
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_PROBE: begin
          state <= (lo < hi) ? S_CMP : S_HIT;
        end
        S_CMP: begin
          if (mem_rdata.key < key_q) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_PROBE;
        end
        S_HIT: begin
          pend <= 1'b0;
          unique case (cmd_q)
            CMD_FIND: begin
              res_status <= hit ? ST_FOUND : ST_MISSING;
              res_value  <= hit ? mem_rdata.value : '0;
              state      <= S_EMIT;
            end
            CMD_INSERT: begin
              if (hit) begin
                res_status <= ST_UPDATED;
                state      <= S_EMIT;
              end else if (count >= CAP_C) begin
                res_status <= ST_FULL;
                state      <= S_EMIT;
              end else if (lo == count) begin
                state <= S_PLACE;
              end else begin
                rd_ptr   <= count - 1'b1;
                rd_more  <= 1'b1;
                shift_up <= 1'b1;
                state    <= S_SHIFT;
              end
            end
            default: begin
              // remove
              if (!hit) begin
                res_status <= ST_MISSING;
                state      <= S_EMIT;
              end else if (lo + 1'b1 == count) begin
                count      <= count - 1'b1;
                res_status <= ST_REMOVED;
                state      <= S_EMIT;
              end else begin
                rd_ptr   <= lo + 1'b1;
                rd_more  <= 1'b1;
                shift_up <= 1'b0;
                state    <= S_SHIFT;
              end
            end
          endcase
        end
        S_SHIFT: begin
          pend      <= rd_more;
          pend_addr <= shift_up ? rd_ptr + 1'b1 : rd_ptr - 1'b1;
          if (rd_more) begin
            rd_more <= !shift_last;
            rd_ptr  <= shift_up ? rd_ptr - 1'b1 : rd_ptr + 1'b1;
          end else begin
            // last pending write goes out this cycle
            if (shift_up) begin
              state <= S_PLACE;
            end else begin
              count      <= count - 1'b1;
              res_status <= ST_REMOVED;
              state      <= S_EMIT;
            end
          end
        end
        S_PLACE: begin
          count      <= count + 1'b1;
          res_status <= ST_INSERTED;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DREAD: begin
          state <= S_DEMIT;
        end
        S_DEMIT: begin
          if (out_free) begin
            if (dump_ptr == count - 1'b1) begin
              state <= S_IDLE;
            end else begin
              dump_ptr <= dump_ptr + 1'b1;
              state    <= S_DREAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  skvm_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  skvm_outreg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_load),
    .din   (res_word),
    .free  (out_free),
    .valid (rsp_valid),
    .ready (rsp_ready),
    .dout  (rsp)
  );

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("entry count above capacity");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same entry in one cycle");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> (count == $past(count) + 1'b1) ||
                        (count == $past(count) - 1'b1) || (count == '0))
    else $error("entry count moved by more than one");
  a_accept_idle_out: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> !res_load)
    else $error("result loaded in the accepting cycle");
`endif

endmodule

FILE: verif/sorted_key_value_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_map_tb: self-checking bench for the sorted key/value map
// Directed and random commands with random idling on both sides; every result
// word is checked against a behavioral copy of the sorted table or a word written by hand.
// ----------------------------------------------------------------------------
module sorted_key_value_map_tb;
  import skvm_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int LONG_HOLD    = 300;   // one long consumer stall, fills the block up
  localparam int STALL_LIMIT  = 2000;  // cycles with no accepted word before giving up
  localparam int DRAIN_CYCLES = 200;   // quiet stretch after the last expected word
  localparam int REPORT_MAX   = 10;

  // command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  // one row of the directed plan; want is used only when typed is set
  typedef struct packed {
    req_t word;
    logic typed;
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // shadow copy of the sorted table
  logic [KEY_W-1:0] map_keys [CAPACITY];
  logic [VAL_W-1:0] map_vals [CAPACITY];
  int               map_count = 0;

  rsp_t      expected_words[$];
  plan_row_t plan[$];
  int        bad_words      = 0;
  int        send_calm      = 0;
  int        recv_calm      = 0;
  int        long_hold_asks = 0;
  int        idle_cycles    = 0;

  sorted_key_value_map #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a run that stops moving words is a failure
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // table shadow
  // ---------------------------------------------------------------------------

  // first slot whose key is not below k
  function automatic int find_slot(logic [KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = map_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (map_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // result word as seen after the table has been updated
  function automatic void queue_result(logic [ST_W-1:0] st, logic [KEY_W-1:0] k,
                                       logic [VAL_W-1:0] v, logic lst);
    rsp_t w;
    w.status      = st;
    w.out_key     = k;
    w.out_value   = v;
    w.entry_count = CNT_W'(map_count);
    w.last        = lst;
    expected_words.push_back(w);
  endfunction

  // apply one accepted command to the shadow table and queue its result words
  function automatic void predict_map(req_t w);
    int   pos;
    logic hit;
    pos = find_slot(w.key);
    hit = (pos < map_count) && (map_keys[pos] == w.key);
    case (w.cmd)
      CMD_INSERT: begin
        if (hit) begin
          map_vals[pos] = w.value;
          queue_result(ST_UPDATED, w.key, '0, 1'b1);
        end else if (map_count >= CAPACITY) begin
          // new key into a full table is refused, nothing moves
          queue_result(ST_FULL, w.key, '0, 1'b1);
        end else begin
          for (int i = map_count; i > pos; i--) begin
            map_keys[i] = map_keys[i-1];
            map_vals[i] = map_vals[i-1];
          end
          map_keys[pos] = w.key;
          map_vals[pos] = w.value;
          map_count++;
          queue_result(ST_INSERTED, w.key, '0, 1'b1);
        end
      end
      CMD_FIND: begin
        if (hit) queue_result(ST_FOUND, w.key, map_vals[pos], 1'b1);
        else queue_result(ST_MISSING, w.key, '0, 1'b1);
      end
      CMD_REMOVE: begin
        if (!hit) begin
          queue_result(ST_MISSING, w.key, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < map_count; i++) begin
            map_keys[i] = map_keys[i+1];
            map_vals[i] = map_vals[i+1];
          end
          map_count--;
          queue_result(ST_REMOVED, w.key, '0, 1'b1);
        end
      end
      CMD_CLEAR: begin
        map_count = 0;
        queue_result(ST_CLEARED, w.key, '0, 1'b1);
      end
      CMD_DUMP: begin
        // empty table still answers with one word echoing the key
        if (map_count == 0) begin
          queue_result(ST_EMPTY, w.key, '0, 1'b1);
        end else begin
          for (int i = 0; i < map_count; i++) begin
            queue_result(ST_DUMP, map_keys[i], map_vals[i], i + 1 == map_count);
          end
        end
      end
      default: ;  // spare codes are dropped without a result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t make_word(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                     logic [VAL_W-1:0] v);
    req_t w;
    w.cmd   = c;
    w.key   = k;
    w.value = v;
    return w;
  endfunction

  function automatic void plan_checked(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                       logic [VAL_W-1:0] v);
    plan_row_t row;
    row.word  = make_word(c, k, v);
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  // row whose single result word is written out by hand
  function automatic void plan_typed(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                     logic [VAL_W-1:0] v, logic [ST_W-1:0] st,
                                     logic [KEY_W-1:0] ok, logic [VAL_W-1:0] ov,
                                     logic [CNT_W-1:0] cnt);
    plan_row_t row;
    row.word              = make_word(c, k, v);
    row.typed             = 1'b1;
    row.want.status       = st;
    row.want.out_key      = ok;
    row.want.out_value    = ov;
    row.want.entry_count  = cnt;
    row.want.last         = 1'b1;
    plan.push_back(row);
  endfunction

  // mostly keys already in the table, plus extremes, near misses and noise
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (map_count > 0 && r < 6) return map_keys[$urandom_range(0, map_count - 1)];
    if (r == 6) return '0;
    if (r == 7) return '1;
    if (map_count > 0 && r == 8) return map_keys[$urandom_range(0, map_count - 1)] + 1'b1;
    return $urandom();
  endfunction

  // idle gap before the next word, with occasional stretches of no idling
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(4, 16);
      gap  = 0;
    end else begin
      gap = $urandom_range(0, 9);
    end
  endtask

  // offer one command word and hold it until taken; valid stays up when the
  // next word follows without a gap
  task automatic send_word(input req_t w, input logic typed, input rsp_t want);
    int gap;
    draw_gap(send_calm, gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_map(w);
    if (typed) begin
      void'(expected_words.pop_back());
      expected_words.push_back(want);
    end
  endtask

  task automatic send_mixed(input int n);
    int               r;
    logic [CMD_W-1:0] c;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) c = CMD_INSERT;
      else if (r < 60) c = CMD_FIND;
      else if (r < 80) c = CMD_REMOVE;
      else if (r < 87) c = CMD_DUMP;
      else if (r < 91) c = CMD_CLEAR;
      else c = CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
      send_word(make_word(c, pick_key(), $urandom()), 1'b0, '0);
    end
  endtask

  // compare one accepted result word against the oldest expectation
  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (expected_words.size() == 0) begin
      bad_words++;
      if (bad_words <= REPORT_MAX)
        $display("unexpected result word: status %0d key %h value %h count %0d last %b",
                 got.status, got.out_key, got.out_value, got.entry_count, got.last);
      return;
    end
    want = expected_words.pop_front();
    if (got.status !== want.status || got.out_key !== want.out_key ||
        got.out_value !== want.out_value || got.entry_count !== want.entry_count ||
        got.last !== want.last) begin
      bad_words++;
      if (bad_words <= REPORT_MAX) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected status %0d key %h value %h count %0d last %b",
                 want.status, want.out_key, want.out_value, want.entry_count, want.last);
        $display("  actual   status %0d key %h value %h count %0d last %b",
                 got.status, got.out_key, got.out_value, got.entry_count, got.last);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random ready, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receive_words
    int gap;
    int holds_done;
    holds_done = 0;
    rsp_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold_asks > holds_done) begin
        holds_done++;
        gap = LONG_HOLD;
      end else begin
        draw_gap(recv_calm, gap);
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_result(rsp);
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------
  initial begin : drive_commands
    req_valid <= 1'b0;
    req       <= '0;

    // directed plan: empty table, key extremes, update, hit and miss,
    // ignored codes, clear and dumps of empty and filled tables
    plan_typed(CMD_FIND, 32'h0000_1234, '0, ST_MISSING, 32'h0000_1234, '0, 0);
    plan_typed(CMD_DUMP, 32'hDEAD_BEEF, '0, ST_EMPTY, 32'hDEAD_BEEF, '0, 0);
    plan_typed(CMD_REMOVE, 32'h0000_0005, '0, ST_MISSING, 32'h0000_0005, '0, 0);
    plan_typed(CMD_INSERT, '1, '1, ST_INSERTED, '1, '0, 1);
    plan_typed(CMD_INSERT, '0, '0, ST_INSERTED, '0, '0, 2);
    plan_typed(CMD_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, ST_INSERTED, 32'h8000_0000, '0, 3);
    plan_typed(CMD_INSERT, '0, '1, ST_UPDATED, '0, '0, 3);
    plan_typed(CMD_FIND, '0, '0, ST_FOUND, '0, '1, 3);
    plan_typed(CMD_FIND, '1, '0, ST_FOUND, '1, '1, 3);
    plan_typed(CMD_FIND, 32'h7FFF_FFFF, '0, ST_MISSING, 32'h7FFF_FFFF, '0, 3);
    plan_checked(CMD_INSERT, 32'h7FFF_FFFF, 32'h1234_5678);
    plan_checked(CMD_DUMP, 32'h0000_0000, 32'hFFFF_FFFF);
    plan_typed(CMD_REMOVE, 32'h8000_0000, '0, ST_REMOVED, 32'h8000_0000, '0, 3);
    plan_typed(CMD_REMOVE, 32'h8000_0000, '0, ST_MISSING, 32'h8000_0000, '0, 3);
    plan_checked(CMD_SPARE_A, '0, '0);
    plan_checked(CMD_SPARE_B, 32'h5555_5555, 32'hAAAA_AAAA);
    plan_checked(CMD_SPARE_C, '1, '1);
    plan_checked(CMD_REMOVE, '0, '0);
    plan_checked(CMD_DUMP, 32'h1357_9BDF, '0);
    plan_typed(CMD_CLEAR, 32'hA5A5_A5A5, '0, ST_CLEARED, 32'hA5A5_A5A5, '0, 0);
    plan_typed(CMD_DUMP, '0, '0, ST_EMPTY, '0, '0, 0);
    plan_typed(CMD_FIND, '1, '0, ST_MISSING, '1, '0, 0);
    plan_checked(CMD_INSERT, 32'h0000_0001, 32'h8000_0001);
    plan_checked(CMD_FIND, 32'h0000_0001, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);

    // random mix on a small table
    send_mixed(20);

    // fill to capacity with fresh keys in random order
    while (map_count < CAPACITY) send_word(make_word(CMD_INSERT, $urandom(), $urandom()), 1'b0, '0);

    // full table: new keys refused, known keys still updated
    send_word(make_word(CMD_INSERT, $urandom(), $urandom()), 1'b0, '0);
    send_word(make_word(CMD_INSERT, '0, $urandom()), 1'b0, '0);
    send_word(make_word(CMD_INSERT, '1, $urandom()), 1'b0, '0);
    repeat (2) send_word(make_word(CMD_INSERT, map_keys[$urandom_range(0, CAPACITY - 1)],
                                   $urandom()), 1'b0, '0);

    // full dump while the consumer holds off; commands behind it back up
    long_hold_asks++;
    send_word(make_word(CMD_DUMP, $urandom(), $urandom()), 1'b0, '0);
    repeat (4) send_word(make_word(CMD_FIND, pick_key(), $urandom()), 1'b0, '0);
    send_word(make_word(CMD_REMOVE, map_keys[$urandom_range(0, CAPACITY - 1)], '0), 1'b0, '0);
    repeat (2) send_word(make_word(CMD_INSERT, $urandom(), $urandom()), 1'b0, '0);
    send_word(make_word(CMD_DUMP, $urandom(), $urandom()), 1'b0, '0);

    // random mix again, starting from a full table
    send_mixed(25);
    req_valid <= 1'b0;

    // drain: all result words in, then a quiet stretch for strays
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
